### hdl/bsd_pkg.sv
// shared types, character codes and hex helpers for the backslash escape decoder
package bsd_pkg;

  localparam int unsigned MaxOut = 4;
  localparam int unsigned IdxW   = $clog2(MaxOut);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BSL   = 2'd1,
    PH_X     = 2'd2,
    PH_DIGIT = 2'd3
  } phase_e;

  // one accepted character worth of decoded output
  typedef struct packed {
    logic [MaxOut-1:0][7:0] chars;
    logic [IdxW-1:0]        cnt_m1;
    logic                   last;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_F);
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= CH_LOW_A) && (c <= CH_LOW_F);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || is_upper_hex(c) || is_lower_hex(c);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = c - CH_0;
    if (is_upper_hex(c)) begin
      v = c - CH_UP_A + HEX_TEN;
    end else if (is_lower_hex(c)) begin
      v = c - CH_LOW_A + HEX_TEN;
    end
    return v[3:0];
  endfunction

endpackage

### hdl/backslash_escape_decoder.sv
// top level of the backslash escape decoder
//
//   channel  direction  handshake            payload
//   input    in         push / full          char_in_i, input_last_i
//   result   out        empty / pop          char_out_o, run_end_o, string_end_o
//
// one character is taken per cycle while the bundle queue has room
// each character yields zero to four results, sent one per cycle by the back stage while pop keeps up
// the output register sets the pace: a character that expands to k results holds the
// back stage until all k are sent, and the four-entry queue absorbs such bursts
// reset clears the escape state, the queue and the output register
// full rises when the queue holds four bundles, so a long stall on pop backs up into push
module backslash_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       input_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o,
  output logic       run_end_o,
  output logic       string_end_o
);

  logic             accept;
  logic             bundle_valid;
  bsd_pkg::bundle_t bundle;
  bsd_pkg::bundle_t q_data;
  logic             q_empty, q_pop;

  assign accept = push && !full;

  bsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_in_i      (char_in_i),
    .input_last_i   (input_last_i),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  bsd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (bundle_valid),
    .wr_data_i (bundle),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  bsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .char_out_o   (char_out_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

endmodule

### hdl/bsd_front.sv
// front stage: escape state tracking and classification of each character
module bsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_in_i,
  input  logic             input_last_i,
  output logic             bundle_valid_o,
  output bsd_pkg::bundle_t bundle_o
);

  bsd_pkg::phase_e phase_q, phase_d, phase_mid;
  logic [7:0]      held_q, held_d;
  logic [bsd_pkg::IdxW:0] n;

  // next state
  always_comb begin
    phase_mid = phase_q;
    held_d    = held_q;
    unique case (phase_q)
      bsd_pkg::PH_IDLE: begin
        if (char_in_i == bsd_pkg::CH_BSL) phase_mid = bsd_pkg::PH_BSL;
      end
      bsd_pkg::PH_BSL: begin
        phase_mid = (char_in_i == bsd_pkg::CH_X) ? bsd_pkg::PH_X : bsd_pkg::PH_IDLE;
      end
      bsd_pkg::PH_X: begin
        if (bsd_pkg::is_hex(char_in_i)) begin
          held_d    = char_in_i;
          phase_mid = bsd_pkg::PH_DIGIT;
        end else if (char_in_i == bsd_pkg::CH_BSL) begin
          phase_mid = bsd_pkg::PH_BSL;
        end else begin
          phase_mid = bsd_pkg::PH_IDLE;
        end
      end
      bsd_pkg::PH_DIGIT: begin
        if (!bsd_pkg::is_hex(char_in_i) && (char_in_i == bsd_pkg::CH_BSL)) begin
          phase_mid = bsd_pkg::PH_BSL;
        end else begin
          phase_mid = bsd_pkg::PH_IDLE;
        end
      end
      default: phase_mid = bsd_pkg::PH_IDLE;
    endcase
    phase_d = input_last_i ? bsd_pkg::PH_IDLE : phase_mid;
  end

  // outputs
  always_comb begin
    bundle_o.chars = '0;
    n              = '0;
    unique case (phase_q)
      bsd_pkg::PH_IDLE: begin
        if (char_in_i != bsd_pkg::CH_BSL) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = char_in_i; n = n + 1'b1;
        end
      end
      bsd_pkg::PH_BSL: begin
        if (char_in_i == bsd_pkg::CH_BSL) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
        end else if (char_in_i == bsd_pkg::CH_N) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_LF; n = n + 1'b1;
        end else if (char_in_i == bsd_pkg::CH_R) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_CR; n = n + 1'b1;
        end else if (char_in_i != bsd_pkg::CH_X) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = char_in_i; n = n + 1'b1;
        end
      end
      bsd_pkg::PH_X: begin
        if (!bsd_pkg::is_hex(char_in_i)) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_X; n = n + 1'b1;
          if (char_in_i != bsd_pkg::CH_BSL) begin
            bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = char_in_i; n = n + 1'b1;
          end
        end
      end
      bsd_pkg::PH_DIGIT: begin
        if (bsd_pkg::is_hex(char_in_i)) begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] =
            {bsd_pkg::hex_val(held_q), bsd_pkg::hex_val(char_in_i)};
          n = n + 1'b1;
        end else begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_X; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = held_q; n = n + 1'b1;
          if (char_in_i != bsd_pkg::CH_BSL) begin
            bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = char_in_i; n = n + 1'b1;
          end
        end
      end
      default: ;
    endcase
    // flush a cut-off escape at end of string
    if (input_last_i) begin
      unique case (phase_mid)
        bsd_pkg::PH_BSL: begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
        end
        bsd_pkg::PH_X: begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_X; n = n + 1'b1;
        end
        bsd_pkg::PH_DIGIT: begin
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_BSL; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = bsd_pkg::CH_X; n = n + 1'b1;
          bundle_o.chars[n[bsd_pkg::IdxW-1:0]] = held_d; n = n + 1'b1;
        end
        default: ;
      endcase
    end
    bundle_o.cnt_m1 = bsd_pkg::IdxW'(n - 1'b1);
    bundle_o.last   = input_last_i;
    bundle_valid_o  = accept_i && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bsd_pkg::PH_IDLE;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

### hdl/bsd_fifo.sv
// short queue of decoded bundles between front and back
module bsd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  bsd_pkg::bundle_t wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output bsd_pkg::bundle_t rd_data_o,
  output logic             empty_o
);

  bsd_pkg::bundle_t        mem_q [bsd_pkg::QDepth];
  logic [bsd_pkg::QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [bsd_pkg::QAw:0]   cnt_q;

  assign full_o    = (cnt_q == (bsd_pkg::QAw + 1)'(bsd_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hdl/bsd_back.sv
// back stage: serializes each bundle into single characters with an output register
module bsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  bsd_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       char_out_o,
  output logic             run_end_o,
  output logic             string_end_o
);

  logic [bsd_pkg::IdxW-1:0] idx_q;
  logic                     out_valid_q;
  logic [7:0]               char_q;
  logic                     run_end_q, str_end_q;
  logic                     load, at_end;

  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign at_end  = (idx_q == q_data_i.cnt_m1);
  assign q_pop_o = load && at_end;

  assign empty_o      = !out_valid_q;
  assign char_out_o   = char_q;
  assign run_end_o    = run_end_q;
  assign string_end_o = str_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_end ? '0 : idx_q + 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q    <= q_data_i.chars[idx_q];
      run_end_q <= at_end;
      str_end_q <= at_end && q_data_i.last;
    end
  end

endmodule

### verif/backslash_escape_decoder_tb.sv
// self-checking testbench for the backslash escape decoder with a built-in decoding predictor
`timescale 1ns / 100ps

module backslash_escape_decoder_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam logic [4:0] NoNibble = 5'd16;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } raw_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       str_end;
  } decoded_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_in_i = 8'h00;
  logic       input_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] char_out_o;
  logic       run_end_o;
  logic       string_end_o;

  raw_char_t raw_q[$];
  decoded_t  decoded_q[$];
  logic [7:0] step_out[$];

  bsd_pkg::phase_e esc_phase = bsd_pkg::PH_IDLE;
  logic [7:0]      first_digit = 8'h00;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned items_queued = 0;

  backslash_escape_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_in_i    (char_in_i),
    .input_last_i (input_last_i),
    .empty        (empty),
    .pop          (pop),
    .char_out_o   (char_out_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= bsd_pkg::CH_0 && c <= bsd_pkg::CH_9) begin
      d = c - bsd_pkg::CH_0;
    end else if (c >= bsd_pkg::CH_UP_A && c <= bsd_pkg::CH_UP_F) begin
      d = c - bsd_pkg::CH_UP_A + bsd_pkg::HEX_TEN;
    end else if (c >= bsd_pkg::CH_LOW_A && c <= bsd_pkg::CH_LOW_F) begin
      d = c - bsd_pkg::CH_LOW_A + bsd_pkg::HEX_TEN;
    end else begin
      return NoNibble;
    end
    return {1'b0, d[3:0]};
  endfunction

  task automatic take_plain(input logic [7:0] c);
    if (c == bsd_pkg::CH_BSL) begin
      esc_phase = bsd_pkg::PH_BSL;
    end else begin
      step_out.push_back(c);
    end
  endtask

  task automatic decode_step(input logic [7:0] c, input logic is_last);
    logic [4:0] lo_nib;
    logic [4:0] hi_nib;
    decoded_t   res;
    int         k;
    step_out.delete();
    case (esc_phase)
      bsd_pkg::PH_IDLE: begin
        take_plain(c);
      end
      bsd_pkg::PH_BSL: begin
        esc_phase = bsd_pkg::PH_IDLE;
        if (c == bsd_pkg::CH_BSL) begin
          step_out.push_back(bsd_pkg::CH_BSL);
        end else if (c == bsd_pkg::CH_N) begin
          step_out.push_back(bsd_pkg::CH_LF);
        end else if (c == bsd_pkg::CH_R) begin
          step_out.push_back(bsd_pkg::CH_CR);
        end else if (c == bsd_pkg::CH_X) begin
          esc_phase = bsd_pkg::PH_X;
        end else begin
          step_out.push_back(bsd_pkg::CH_BSL);
          take_plain(c);
        end
      end
      bsd_pkg::PH_X: begin
        if (nibble_of(c) != NoNibble) begin
          first_digit = c;
          esc_phase = bsd_pkg::PH_DIGIT;
        end else begin
          esc_phase = bsd_pkg::PH_IDLE;
          step_out.push_back(bsd_pkg::CH_BSL);
          step_out.push_back(bsd_pkg::CH_X);
          take_plain(c);
        end
      end
      default: begin
        lo_nib = nibble_of(c);
        hi_nib = nibble_of(first_digit);
        esc_phase = bsd_pkg::PH_IDLE;
        if (lo_nib != NoNibble) begin
          step_out.push_back({hi_nib[3:0], lo_nib[3:0]});
        end else begin
          step_out.push_back(bsd_pkg::CH_BSL);
          step_out.push_back(bsd_pkg::CH_X);
          step_out.push_back(first_digit);
          take_plain(c);
        end
      end
    endcase
    if (is_last) begin
      case (esc_phase)
        bsd_pkg::PH_BSL: begin
          step_out.push_back(bsd_pkg::CH_BSL);
        end
        bsd_pkg::PH_X: begin
          step_out.push_back(bsd_pkg::CH_BSL);
          step_out.push_back(bsd_pkg::CH_X);
        end
        bsd_pkg::PH_DIGIT: begin
          step_out.push_back(bsd_pkg::CH_BSL);
          step_out.push_back(bsd_pkg::CH_X);
          step_out.push_back(first_digit);
        end
        default: begin
        end
      endcase
      esc_phase = bsd_pkg::PH_IDLE;
    end
    for (k = 0; k < step_out.size(); k++) begin
      res.ch = step_out[k];
      res.run_end = (k == step_out.size() - 1);
      res.str_end = res.run_end && is_last;
      decoded_q.push_back(res);
    end
  endtask

  task automatic check_decoded();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      error_cnt++;
      if (error_cnt <= 10) begin
        $display("unexpected transfer: char %h run_end %b string_end %b",
                 char_out_o, run_end_o, string_end_o);
      end
    end else begin
      want = decoded_q.pop_front();
      if (char_out_o !== want.ch || run_end_o !== want.run_end
          || string_end_o !== want.str_end) begin
        error_cnt++;
        if (error_cnt <= 10) begin
          $display("mismatch: expected char %h run_end %b string_end %b, got %h %b %b",
                   want.ch, want.run_end, want.str_end,
                   char_out_o, run_end_o, string_end_o);
        end
      end
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      char_in_i <= 8'h00;
      input_last_i <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_step(char_in_i, input_last_i);
        void'(raw_q.pop_front());
      end
      if (!(push && full)) begin
        if (raw_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push <= 1'b1;
          char_in_i <= raw_q[0].ch;
          input_last_i <= raw_q[0].is_last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_decoded();
      end
      pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_req;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == bsd_pkg::CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) begin
      return bsd_pkg::CH_0 + 8'(idx);
    end else if (idx < 16) begin
      return bsd_pkg::CH_UP_A + 8'(idx - 10);
    end
    return bsd_pkg::CH_LOW_A + 8'(idx - 16);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (nibble_of(c) != NoNibble);
    return c;
  endfunction

  task automatic queue_chars(input logic [7:0] s[$]);
    raw_char_t item;
    int        i;
    for (i = 0; i < s.size(); i++) begin
      item.ch = s[i];
      item.is_last = (i == s.size() - 1);
      raw_q.push_back(item);
    end
    items_queued += s.size();
  endtask

  // plain bytes and well-formed escapes with random content, some broken ones and raw noise
  task automatic queue_string();
    logic [7:0]  s[$];
    int unsigned n_tok;
    int unsigned kind;
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        s.push_back(plain_byte());
      end else if (kind < 40) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(bsd_pkg::CH_BSL);
      end else if (kind < 48) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(bsd_pkg::CH_N);
      end else if (kind < 56) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(bsd_pkg::CH_R);
      end else if (kind < 75) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(bsd_pkg::CH_X);
        s.push_back(hex_char());
        s.push_back(hex_char());
      end else if (kind < 82) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(bsd_pkg::CH_X);
        s.push_back(($urandom_range(0, 1) != 0) ? non_hex_char() : bsd_pkg::CH_BSL);
      end else if (kind < 93) begin
        s.push_back(bsd_pkg::CH_BSL);
        s.push_back(bsd_pkg::CH_X);
        s.push_back(hex_char());
        s.push_back(($urandom_range(0, 1) != 0) ? non_hex_char() : bsd_pkg::CH_BSL);
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    // cut-off escape at the end of the string
    kind = $urandom_range(0, 11);
    if (kind < 3) begin
      s.push_back(bsd_pkg::CH_BSL);
      if (kind > 0) begin
        s.push_back(bsd_pkg::CH_X);
      end
      if (kind > 1) begin
        s.push_back(hex_char());
      end
    end
    queue_chars(s);
  endtask

  task automatic drain();
    while (raw_q.size() != 0 || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(33, 67);

    queue_chars('{8'h00});
    queue_chars('{8'hFF});
    queue_chars('{bsd_pkg::CH_BSL, bsd_pkg::CH_BSL, bsd_pkg::CH_BSL, bsd_pkg::CH_N,
                  bsd_pkg::CH_BSL, bsd_pkg::CH_R});
    queue_chars('{bsd_pkg::CH_BSL, bsd_pkg::CH_X, bsd_pkg::CH_UP_A, bsd_pkg::CH_LOW_F});
    // bad character after a backslash, bad first hex digit
    queue_chars('{bsd_pkg::CH_BSL, 8'h71, bsd_pkg::CH_BSL, bsd_pkg::CH_X, 8'h67});
    // bad second hex digit that opens a new escape, cut off at the end
    queue_chars('{bsd_pkg::CH_BSL, bsd_pkg::CH_X, bsd_pkg::CH_9, bsd_pkg::CH_BSL});
    queue_chars('{bsd_pkg::CH_BSL, bsd_pkg::CH_X});
    queue_chars('{bsd_pkg::CH_BSL, bsd_pkg::CH_X, bsd_pkg::CH_0});

    while (items_queued < 120) begin
      queue_string();
    end
    drain();

    set_idling(67, 33);
    while (items_queued < 210) begin
      queue_string();
    end
    drain();

    set_idling(0, 0);
    hold_req = hold_req + 1;
    while (items_queued < 250) begin
      queue_string();
    end
    drain();

    while (items_queued < 310) begin
      queue_string();
    end
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0 && decoded_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
